// ===== design/flow_hash_tunnel_selector_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef FLOW_HASH_TUNNEL_SELECTOR_UNIT_DEFINES_SVH
`define FLOW_HASH_TUNNEL_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst is high.
`define FHTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while rst is high.
`define FHTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fhts_pkg.sv =====
package fhts_pkg;

  localparam int MAX_TUNNELS     = 4;
  localparam int MAX_QUEUE_COUNT = 16;
  localparam int QUEUE_REGS      = 4;
  localparam int TUNNEL_LIMIT    = (MAX_TUNNELS < QUEUE_REGS) ? MAX_TUNNELS : QUEUE_REGS;

  localparam logic [11:0] ETH_HEAD     = 12'd14;
  localparam logic [12:0] IPV4_MIN_LEN = 13'd34;
  localparam logic [12:0] ENCAP_EXTRA  = 13'd22;
  localparam logic [15:0] IPV4_KIND    = 16'h0800;

  localparam int KEY_BYTES = 25;
  localparam logic [4:0] KEY_LEN_MAC  = 5'd12;
  localparam logic [4:0] KEY_LEN_IP   = 5'd21;
  localparam logic [4:0] KEY_LEN_FULL = 5'd25;

  typedef enum logic [2:0] {
    CFG_TUNNEL_COUNT = 3'd0,
    CFG_TUNNEL0_Q    = 3'd1,
    CFG_TUNNEL1_Q    = 3'd2,
    CFG_TUNNEL2_Q    = 3'd3,
    CFG_TUNNEL3_Q    = 3'd4,
    CFG_SOURCE_QUEUE = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] ether_kind;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_proto;
    logic [3:0]  ip_header_words;
    logic [31:0] l4_head;
    logic [11:0] frame_length;
  } fhts_in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  tunnel_index;
    logic [3:0]  tunnel_queue;
    logic [15:0] encap_id;
    logic [31:0] flow_hash;
    logic [12:0] encap_length;
  } fhts_out_t;

endpackage

// ===== design/flow_hash_tunnel_selector_unit.sv =====
// Channel   Signals                            Moves
// in        in_valid / in_ready / in_data      one frame header per transaction
// out       out_valid / out_ready / out_data   one selection result per transaction
// cfg       cfg_valid / cfg_ready / cfg_index  one register write per transaction
//           / cfg_data
// A dropped frame goes from idle straight to the done state; otherwise the hash folds
// the key bytes (12, 21 or 25) one key byte a cycle, a final mix follows, and a shared
// remainder unit takes four hash bits a cycle, then the queue in one step.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next frame is taken while it waits.
// Reset is synchronous; configuration writes are taken in every cycle.
module flow_hash_tunnel_selector_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fhts_pkg::fhts_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fhts_pkg::fhts_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [4:0]        cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_FINAL = 6'b000100,
    S_MODT  = 6'b001000,
    S_MODQ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [2:0]  tunnel_count;
  logic [4:0]  tunnel_queues [fhts_pkg::QUEUE_REGS];
  logic [3:0]  source_queue;
  logic [11:0] message_counter;

  logic [8*fhts_pkg::KEY_BYTES-1:0] key;
  logic [4:0]  bytes_left;
  logic [31:0] h;
  logic [2:0]  step_cnt;
  logic [4:0]  rem;
  logic [3:0]  queue_rem;
  logic        drop;
  logic [11:0] frame_len;

  function automatic logic [31:0] mix_byte(input logic [31:0] hv, input logic [7:0] b);
    logic [31:0] t;
    t = hv + 32'(b);
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [31:0] finish_hash(input logic [31:0] hv);
    logic [31:0] t;
    t = hv + (hv << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

  // Four restoring remainder steps; the running remainder stays below the divisor.
  function automatic logic [4:0] mod_step(input logic [4:0] r, input logic [3:0] d,
                                          input logic [4:0] div);
    logic [5:0] x;
    x = 6'(r);
    for (int i = 3; i >= 0; i--) begin
      x = {x[4:0], d[i]};
      if (x >= 6'(div)) begin
        x = x - 6'(div);
      end
    end
    return x[4:0];
  endfunction

  logic [2:0]  tuns;
  logic [4:0]  raw_q;
  logic [4:0]  eff_q;
  logic [4:0]  unit_rem;
  logic [3:0]  unit_digits;
  logic [4:0]  unit_div;
  logic [4:0]  unit_out;
  logic        is_ipv4;
  logic        has_l4;
  logic [4:0]  key_len;
  logic        drop_in;
  fhts_pkg::fhts_out_t result;

  always_comb begin
    tuns = (tunnel_count > 3'(fhts_pkg::TUNNEL_LIMIT)) ? 3'(fhts_pkg::TUNNEL_LIMIT)
                                                       : tunnel_count;
    raw_q = tunnel_queues[rem[1:0]];
    if (raw_q == 5'd0) begin
      eff_q = 5'd1;
    end else if (raw_q > 5'(fhts_pkg::MAX_QUEUE_COUNT)) begin
      eff_q = 5'(fhts_pkg::MAX_QUEUE_COUNT);
    end else begin
      eff_q = raw_q;
    end
  end

  // The one remainder unit serves the tunnel choice and then the queue choice.
  always_comb begin
    if (state == S_MODQ) begin
      unit_rem    = 5'd0;
      unit_digits = source_queue;
      unit_div    = eff_q;
    end else begin
      unit_rem    = rem;
      unit_digits = h[{step_cnt, 2'b00} +: 4];
      unit_div    = 5'(tuns);
    end
    unit_out = mod_step(unit_rem, unit_digits, unit_div);
  end

  always_comb begin
    is_ipv4 = (in_data.ether_kind == fhts_pkg::IPV4_KIND) &&
              (13'(in_data.frame_length) >= fhts_pkg::IPV4_MIN_LEN);
    has_l4  = 13'(in_data.frame_length) >=
              (13'(fhts_pkg::ETH_HEAD) + 13'd4 + {7'd0, in_data.ip_header_words, 2'b00});
    if (!is_ipv4) begin
      key_len = fhts_pkg::KEY_LEN_MAC;
    end else if (has_l4) begin
      key_len = fhts_pkg::KEY_LEN_FULL;
    end else begin
      key_len = fhts_pkg::KEY_LEN_IP;
    end
    drop_in = (in_data.frame_length < fhts_pkg::ETH_HEAD) || (tuns == 3'd0);
  end

  always_comb begin
    result = '0;
    if (!drop) begin
      result.accepted     = 1'b1;
      result.tunnel_index = rem[1:0];
      result.tunnel_queue = queue_rem;
      result.encap_id     = {source_queue, message_counter};
      result.flow_hash    = h;
      result.encap_length = 13'(frame_len) + fhts_pkg::ENCAP_EXTRA;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tunnel_count  <= 3'd0;
      source_queue  <= 4'd0;
      for (int i = 0; i < fhts_pkg::QUEUE_REGS; i++) begin
        tunnel_queues[i] <= 5'd1;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fhts_pkg::CFG_TUNNEL_COUNT: tunnel_count     <= cfg_data[2:0];
        fhts_pkg::CFG_TUNNEL0_Q:    tunnel_queues[0] <= cfg_data;
        fhts_pkg::CFG_TUNNEL1_Q:    tunnel_queues[1] <= cfg_data;
        fhts_pkg::CFG_TUNNEL2_Q:    tunnel_queues[2] <= cfg_data;
        fhts_pkg::CFG_TUNNEL3_Q:    tunnel_queues[3] <= cfg_data;
        fhts_pkg::CFG_SOURCE_QUEUE: source_queue     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      message_counter <= 12'd0;
    end else begin
      // In S_DONE the output register is handled by the state arm below.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= drop_in ? S_DONE : S_HASH;
          end
        end
        S_HASH: begin
          if (bytes_left == 5'd1) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: state <= S_MODT;
        S_MODT: begin
          if (step_cnt == 3'd0) begin
            state <= S_MODQ;
          end
        end
        S_MODQ: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (!drop) begin
              message_counter <= message_counter + 12'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        key        <= {in_data.src_mac, in_data.dst_mac, in_data.src_ip, in_data.dst_ip,
                       in_data.ip_proto, in_data.l4_head};
        bytes_left <= key_len;
        h          <= 32'd0;
        drop       <= drop_in;
        frame_len  <= in_data.frame_length;
      end
      S_HASH: begin
        h          <= mix_byte(h, key[8*fhts_pkg::KEY_BYTES-1 -: 8]);
        key        <= key << 8;
        bytes_left <= bytes_left - 5'd1;
      end
      S_FINAL: begin
        h        <= finish_hash(h);
        step_cnt <= 3'd7;
        rem      <= 5'd0;
      end
      S_MODT: begin
        rem      <= unit_out;
        step_cnt <= step_cnt - 3'd1;
      end
      S_MODQ: queue_rem <= unit_out[3:0];
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_data <= result;
        end
      end
    endcase
  end

endmodule

// ===== design/fhts_checker.sv =====
`include "flow_hash_tunnel_selector_unit_defines.svh"

module fhts_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fhts_pkg::fhts_out_t out_data
);

  // A result that is not taken stays put.
  `FHTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // A dropped frame carries no selection at all.
  `FHTS_ASSERT_NOW(a_drop_zero, out_valid && !out_data.accepted, out_data.flow_hash == 32'd0 && out_data.encap_id == 16'd0 && out_data.encap_length == 13'd0 && out_data.tunnel_index == 2'd0 && out_data.tunnel_queue == 4'd0, "dropped result has nonzero fields")

  // A forwarded frame was at least an Ethernet header long.
  `FHTS_ASSERT_NOW(a_fwd_len, out_valid && out_data.accepted, out_data.encap_length >= 13'd36, "forwarded frame too short")

  // Only one frame is in work at a time.
  `FHTS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second frame taken while busy")

endmodule

bind flow_hash_tunnel_selector_unit fhts_checker u_fhts_checker (.*);
